@@ rtl/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the life-like automaton step block: payload
// structs, action codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;

   localparam int MASK_W      = 9;
   localparam int GEN_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [MASK_W-1:0] BIRTH_RESET    = 9'd8;
   localparam logic [MASK_W-1:0] SURVIVAL_RESET = 9'd12;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVAL = 2'd1;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_ADVANCE = 2'd1,
      ACT_READ    = 2'd2,
      ACT_FILL    = 2'd3
   } lca_action_type;

   typedef struct packed {
      lca_action_type action;
      logic [5:0]     column;
      logic [5:0]     row;
      logic [12:0]    run_length;
      logic           cell_value;
   } lca_req_type;

   typedef struct packed {
      logic             alive;
      logic             changed;
      logic [GEN_W-1:0] generation;
      logic             overrun;
   } lca_rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WB,
      ST_RD_SEEK,
      ST_RD_DATA,
      ST_ADV_LAST_RD,
      ST_ADV_FIRST_RD,
      ST_ADV_PRIME,
      ST_ADV_ROW,
      ST_ADV_TAIL,
      ST_FILL,
      ST_RESP
   } lca_state_type;

endpackage

@@ rtl/life_like_automaton_step_top.sv @@
// ----------------------------------------------------------------------------
// life_like_automaton_step_top
// Toroidal life-like automaton held row by row in two memories with one write
// port and one read port each (cells and changed marks), one row word per grid row.
// ----------------------------------------------------------------------------
// advance: reads the last row and row 0, then ST_ADV_ROW reads one row and writes one row per cycle
// write run: ST_WR_RD reads each touched row, ST_WR_WB writes it back; fill writes every row
// read: ST_RD_SEEK steps row by row while the column runs past a row, then ST_RD_DATA takes the cell
// one item in flight at a time, since req_stall is high outside ST_IDLE; result registered
// after reset a clearing pass in ST_INIT zeroes every row of both memories
// ----------------------------------------------------------------------------
module life_like_automaton_step_top #(
   parameter int GRID_WIDTH  = lca_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = lca_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lca_pkg::lca_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lca_pkg::lca_rsp_type                rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [lca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lca_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import lca_pkg::*;

   localparam int IDX_W  = $clog2((GRID_HEIGHT + 64) * GRID_WIDTH + 8192 + 64);
   localparam int RC_W   = $clog2(GRID_HEIGHT + 64);
   localparam int ROW_AW = $clog2(GRID_HEIGHT);
   localparam int CB     = $clog2(GRID_WIDTH);

   localparam logic [IDX_W-1:0] CELLS    = IDX_W'(GRID_WIDTH * GRID_HEIGHT);
   localparam logic [IDX_W-1:0] W_IDX    = IDX_W'(GRID_WIDTH);
   localparam logic [RC_W-1:0]  LAST_ROW = RC_W'(GRID_HEIGHT - 1);

   lca_state_type state_ff, state_in;

   logic [RC_W-1:0]       row_ff, row_in;
   logic [IDX_W-1:0]      base_ff, base_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic [IDX_W-1:0]      end_ff, end_in;
   logic                  value_ff, value_in;
   logic [GRID_WIDTH-1:0] up_ff, up_in;
   logic [GRID_WIDTH-1:0] cur_ff, cur_in;
   logic [GRID_WIDTH-1:0] first_ff, first_in;
   logic                  any_ff, any_in;
   logic [GEN_W-1:0]      gen_ff, gen_in;
   logic [MASK_W-1:0]     birth_ff, surv_ff;
   logic                  res_alive_ff, res_alive_in;
   logic                  res_changed_ff, res_changed_in;
   logic                  res_overrun_ff, res_overrun_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lca_rsp_type           rsp_payload_ff, rsp_payload_in;

   logic [GRID_WIDTH-1:0] cell_mem [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] chg_mem  [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] cell_rd_ff, chg_rd_ff;
   logic                  mem_we;
   logic [ROW_AW-1:0]     mem_waddr, mem_raddr;
   logic [GRID_WIDTH-1:0] cell_wdata, chg_wdata;

   logic                  req_xfer;
   logic [IDX_W-1:0]      start_calc;
   logic [GRID_WIDTH-1:0] dn_row, new_row, flip_row, run_mask;
   logic [IDX_W-1:0]      run_lo, run_hi, rd_off;
   logic [GEN_W-1:0]      gen_next;

   assign req_xfer   = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign start_calc = IDX_W'(req_payload.row) * W_IDX + IDX_W'(req_payload.column);
   assign gen_next   = (gen_ff == '1) ? gen_ff : gen_ff + GEN_W'(1);
   assign rd_off     = start_ff - base_ff;

   // next generation of one row
   assign dn_row = (state_ff == ST_ADV_TAIL) ? first_ff : cell_rd_ff;

   always_comb begin
      int         cl, cr;
      logic [3:0] cnt;
      logic       was;
      new_row  = '0;
      flip_row = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         cl  = (c == 0) ? GRID_WIDTH - 1 : c - 1;
         cr  = (c == GRID_WIDTH - 1) ? 0 : c + 1;
         cnt = 4'({3'b0, up_ff[cl]}) + 4'({3'b0, up_ff[c]}) + 4'({3'b0, up_ff[cr]})
             + 4'({3'b0, cur_ff[cl]}) + 4'({3'b0, cur_ff[cr]})
             + 4'({3'b0, dn_row[cl]}) + 4'({3'b0, dn_row[c]}) + 4'({3'b0, dn_row[cr]});
         was = cur_ff[c];
         new_row[c]  = was ? surv_ff[cnt] : birth_ff[cnt];
         flip_row[c] = new_row[c] ^ was;
      end
   end

   // lanes of the current row covered by a write run
   assign run_lo = (start_ff > base_ff) ? start_ff - base_ff : '0;
   assign run_hi = end_ff - base_ff;

   always_comb begin
      run_mask = '0;
      for (int c = 0; c < GRID_WIDTH; c++) begin
         run_mask[c] = (IDX_W'(c) >= run_lo) && (IDX_W'(c) < run_hi);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (row_ff == LAST_ROW) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_payload.action)
                  ACT_WRITE:   state_in = ST_WR_RD;
                  ACT_ADVANCE: state_in = ST_ADV_LAST_RD;
                  ACT_READ:    state_in = ST_RD_SEEK;
                  ACT_FILL:    state_in = ST_FILL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_WR_RD: begin
            if (base_ff >= end_ff || base_ff >= CELLS) state_in = ST_RESP;
            else state_in = ST_WR_WB;
         end
         ST_WR_WB:        state_in = ST_WR_RD;
         ST_RD_SEEK: begin
            if (base_ff >= CELLS) state_in = ST_RESP;
            else if (start_ff < base_ff + W_IDX) state_in = ST_RD_DATA;
         end
         ST_RD_DATA:      state_in = ST_RESP;
         ST_ADV_LAST_RD:  state_in = ST_ADV_FIRST_RD;
         ST_ADV_FIRST_RD: state_in = ST_ADV_PRIME;
         ST_ADV_PRIME:    state_in = ST_ADV_ROW;
         ST_ADV_ROW: begin
            if (row_ff == LAST_ROW) state_in = ST_ADV_TAIL;
         end
         ST_ADV_TAIL:     state_in = ST_RESP;
         ST_FILL: begin
            if (row_ff == LAST_ROW) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      row_in         = row_ff;
      base_in        = base_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      value_in       = value_ff;
      up_in          = up_ff;
      cur_in         = cur_ff;
      first_in       = first_ff;
      any_in         = any_ff;
      gen_in         = gen_ff;
      res_alive_in   = res_alive_ff;
      res_changed_in = res_changed_ff;
      res_overrun_in = res_overrun_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_waddr      = row_ff[ROW_AW-1:0];
      mem_raddr      = row_ff[ROW_AW-1:0];
      cell_wdata     = '0;
      chg_wdata      = '0;
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            row_in = (row_ff == LAST_ROW) ? '0 : row_ff + RC_W'(1);
         end
         ST_IDLE: begin
            if (req_xfer) begin
               start_in       = start_calc;
               base_in        = start_calc - IDX_W'(req_payload.column);
               end_in         = start_calc + IDX_W'(req_payload.run_length);
               row_in         = RC_W'(req_payload.row);
               value_in       = req_payload.cell_value;
               res_alive_in   = 1'b0;
               res_changed_in = 1'b0;
               res_overrun_in = (req_payload.action == ACT_WRITE) &&
                                (start_calc + IDX_W'(req_payload.run_length) > CELLS);
               if (req_payload.action == ACT_FILL) begin
                  gen_in = '0;
                  row_in = '0;
               end
            end
         end
         ST_WR_WB: begin
            mem_we     = 1'b1;
            cell_wdata = (cell_rd_ff & ~run_mask) | (value_ff ? run_mask : '0);
            chg_wdata  = chg_rd_ff | run_mask;
            base_in    = base_ff + W_IDX;
            row_in     = row_ff + RC_W'(1);
         end
         ST_RD_SEEK: begin
            if (base_ff < CELLS && start_ff >= base_ff + W_IDX) begin
               base_in = base_ff + W_IDX;
               row_in  = row_ff + RC_W'(1);
            end
         end
         ST_RD_DATA: begin
            res_alive_in   = cell_rd_ff[rd_off[CB-1:0]];
            res_changed_in = chg_rd_ff[rd_off[CB-1:0]];
         end
         ST_ADV_LAST_RD: begin
            mem_raddr = LAST_ROW[ROW_AW-1:0];
         end
         ST_ADV_FIRST_RD: begin
            up_in     = cell_rd_ff;
            any_in    = 1'b0;
            mem_raddr = '0;
         end
         ST_ADV_PRIME: begin
            first_in  = cell_rd_ff;
            cur_in    = cell_rd_ff;
            mem_raddr = ROW_AW'(1);
            row_in    = RC_W'(1);
         end
         ST_ADV_ROW: begin
            mem_we     = 1'b1;
            mem_waddr  = ROW_AW'(row_ff - RC_W'(1));
            cell_wdata = new_row;
            chg_wdata  = flip_row;
            any_in     = any_ff | (|new_row);
            up_in      = cur_ff;
            cur_in     = cell_rd_ff;
            mem_raddr  = ROW_AW'(row_ff + RC_W'(1));
            if (row_ff != LAST_ROW) row_in = row_ff + RC_W'(1);
         end
         ST_ADV_TAIL: begin
            mem_we       = 1'b1;
            mem_waddr    = LAST_ROW[ROW_AW-1:0];
            cell_wdata   = new_row;
            chg_wdata    = flip_row;
            res_alive_in = any_ff | (|new_row);
            gen_in       = gen_next;
         end
         ST_FILL: begin
            mem_we     = 1'b1;
            cell_wdata = {GRID_WIDTH{value_ff}};
            chg_wdata  = {GRID_WIDTH{value_ff}};
            row_in     = row_ff + RC_W'(1);
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.alive      = res_alive_ff;
               rsp_payload_in.changed    = res_changed_ff;
               rsp_payload_in.generation = gen_ff;
               rsp_payload_in.overrun    = res_overrun_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // row memories
   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= cell_wdata;
      cell_rd_ff <= cell_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) chg_mem[mem_waddr] <= chg_wdata;
      chg_rd_ff <= chg_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         birth_ff     <= BIRTH_RESET;
         surv_ff      <= SURVIVAL_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BIRTH:    birth_ff <= csr_wr_data;
               CSR_SURVIVAL: surv_ff  <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff        <= base_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      value_ff       <= value_in;
      up_ff          <= up_in;
      cur_ff         <= cur_in;
      first_ff       <= first_in;
      any_ff         <= any_in;
      res_alive_ff   <= res_alive_in;
      res_changed_ff <= res_changed_in;
      res_overrun_ff <= res_overrun_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // generation moves only on a fill transfer or the last row of an advance
   a_gen_source: assert property (@(posedge clock) disable iff (reset)
      (gen_ff != $past(gen_ff)) |->
         ($past(state_ff) == ST_ADV_TAIL ||
          ($past(req_xfer) && $past(req_payload.action) == ACT_FILL)))
      else $error("generation changed outside fill or advance");

   // advance never writes the row it is fetching
   a_adv_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_ROW && row_ff != LAST_ROW) |-> (mem_waddr != mem_raddr))
      else $error("advance row write collides with row fetch");

   // a finished item always lands in the result register
   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("result lost on completion");

endmodule
